// ----- rtl/wear_leveled_slot_store_core_macros.svh -----
// Assertion macros shared by the slot store checker.
// No dependencies; pull in with `include before use.
`ifndef WEAR_LEVELED_SLOT_STORE_CORE_MACROS_SVH
`define WEAR_LEVELED_SLOT_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WLSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot store check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot store check failed");

`endif

// ----- rtl/wlss_pkg.sv -----
// Shared types and constants for the wear-leveled slot store.
// Used by the controller, the datapath and the top level; no dependencies.
package wlss_pkg;

    localparam int MEM_BYTES_DEF  = 4096;
    localparam int SLOT_COUNT_DEF = 8;
    localparam int CNT_BYTES      = 4;

    localparam logic        OP_WRITE  = 1'b0;
    localparam logic        OP_READ   = 1'b1;
    localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_ZERO = 8'h00;

    localparam logic [1:0] SIZE_1B = 2'd0;
    localparam logic [1:0] SIZE_2B = 2'd1;
    localparam logic [1:0] SIZE_4B = 2'd2;
    localparam logic [1:0] SIZE_8B = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;     // write zero at the clear pointer, advance
        logic load;    // capture a request
        logic scan;    // issue one counter byte read
        logic check;   // settle the chosen slot and its addresses
        logic wcnt;    // write one counter byte
        logic wval;    // write one value byte
        logic rval;    // issue one value byte read
        logic finish;  // present the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic cnt_err;
        logic scan_last;
        logic data_err;
        logic cnt_last;
        logic val_last;
        logic op;
    } t_sts;

endpackage

// ----- rtl/wlss_ctrl.sv -----
// Sequencer of the slot store: clear pass, counter scan, write and read phases.
// Depends on wlss_pkg for the command and status structs.
module wlss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  wlss_pkg::t_sts  i_sts,
    output wlss_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SDRAIN,
        S_CHECK,
        S_WCNT,
        S_WVAL,
        S_RVAL,
        S_RDRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.cnt_err ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                priority if (i_sts.data_err) begin
                    n_state = S_DONE;
                end else if (i_sts.op == wlss_pkg::OP_READ) begin
                    n_state = S_RVAL;
                end else begin
                    n_state = S_WCNT;
                end
            end
            S_WCNT: begin
                o_cmd.wcnt = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_WVAL;
                end
            end
            S_WVAL: begin
                o_cmd.wval = 1'b1;
                if (i_sts.val_last) begin
                    n_state = S_DONE;
                end
            end
            S_RVAL: begin
                o_cmd.rval = 1'b1;
                if (i_sts.val_last) begin
                    n_state = S_RDRAIN;
                end
            end
            S_RDRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/wlss_datapath.sv -----
// Datapath of the slot store: byte memory, counter scan, address and range logic.
// Depends on wlss_pkg; driven by wlss_ctrl commands.
module wlss_datapath #(
    parameter int MEM_BYTES  = wlss_pkg::MEM_BYTES_DEF,
    parameter int SLOT_COUNT = wlss_pkg::SLOT_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wlss_pkg::t_cmd  i_cmd,
    input  logic            i_op,
    input  logic [1:0]      i_size_code,
    input  logic [11:0]     i_data_base,
    input  logic [11:0]     i_counter_base,
    input  logic [63:0]     i_write_value,
    output wlss_pkg::t_sts  o_sts,
    output logic [63:0]     o_read_value,
    output logic [2:0]      o_slot_used,
    output logic            o_status,
    output logic            o_done
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int K_W    = SLOT_W + 2;
    localparam int END_W  = $clog2(MEM_BYTES + 1);
    localparam int CHK_W  = (END_W > 14) ? END_W : 14;

    localparam logic [K_W-1:0]    SCAN_LAST = K_W'(wlss_pkg::CNT_BYTES * SLOT_COUNT - 1);
    localparam logic [K_W-1:0]    CNT_LAST  = K_W'(wlss_pkg::CNT_BYTES - 1);
    localparam logic [CHK_W-1:0]  CNT_SPAN  = CHK_W'(wlss_pkg::CNT_BYTES * SLOT_COUNT);
    localparam logic [CHK_W-1:0]  MEM_END   = CHK_W'(MEM_BYTES);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MEM_BYTES - 1);

    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_op;
    logic [1:0]        r_size;
    logic [11:0]       r_dbase;
    logic [11:0]       r_cbase;
    logic [63:0]       r_wsh;
    logic [K_W-1:0]    r_k;
    logic [31:0]       r_best;
    logic [SLOT_W-1:0] r_slot;
    logic [23:0]       r_cacc;
    logic              r_err;
    logic [CHK_W-1:0]  r_caddr;
    logic [CHK_W-1:0]  r_vaddr;
    logic [31:0]       r_cwr;
    logic              r_rv;
    logic              r_rscan;
    logic [K_W-1:0]    r_rbi;
    logic [63:0]       r_acc;
    logic [63:0]       r_read_value;
    logic [2:0]        r_slot_used;
    logic              r_status;
    logic              r_done;

    logic              cnt_err;
    logic [CHK_W-1:0]  slot_p1;
    logic [CHK_W-1:0]  data_end;
    logic              data_err;
    logic [CHK_W-1:0]  vaddr;
    logic [CHK_W-1:0]  caddr;
    logic [2:0]        val_last_idx;
    logic [31:0]       cval;
    logic              better;
    logic [CHK_W-1:0]  addr_wide;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [63:0]       wsh_load;
    logic [SLOT_W+2:0] slot_ext;
    logic              scan_hit;

    always_comb begin
        cnt_err      = (CHK_W'(i_counter_base) + CNT_SPAN) > MEM_END;
        slot_p1      = CHK_W'(r_slot) + CHK_W'(1);
        data_end     = CHK_W'(r_dbase) + (slot_p1 << r_size);
        data_err     = data_end > MEM_END;
        vaddr        = CHK_W'(r_dbase) + (CHK_W'(r_slot) << r_size);
        caddr        = CHK_W'(r_cbase) + (CHK_W'(r_slot) << 2);
        val_last_idx = 3'((4'd1 << r_size) - 4'd1);
        cval         = {r_cacc, r_rd_data};
        better       = (r_op == wlss_pkg::OP_READ) ? (cval >= r_best) : (cval < r_best);
        scan_hit     = r_rv && r_rscan && (r_rbi[1:0] == 2'b11);
        slot_ext     = {3'b000, r_slot};
    end

    always_comb begin
        unique case (i_size_code)
            wlss_pkg::SIZE_1B: wsh_load = i_write_value << 56;
            wlss_pkg::SIZE_2B: wsh_load = i_write_value << 48;
            wlss_pkg::SIZE_4B: wsh_load = i_write_value << 32;
            wlss_pkg::SIZE_8B: wsh_load = i_write_value;
            default:           wsh_load = i_write_value;
        endcase
    end

    // Single byte port: one access per cycle
    always_comb begin
        priority if (i_cmd.clr) begin
            addr_wide = CHK_W'(r_clr_addr);
        end else if (i_cmd.scan) begin
            addr_wide = CHK_W'(r_cbase) + CHK_W'(r_k);
        end else if (i_cmd.wcnt) begin
            addr_wide = r_caddr + CHK_W'(r_k);
        end else begin
            addr_wide = r_vaddr + CHK_W'(r_k);
        end
        mem_addr = addr_wide[ADDR_W-1:0];
        mem_we   = i_cmd.clr || i_cmd.wcnt || i_cmd.wval;
        priority if (i_cmd.clr) begin
            mem_wdata = wlss_pkg::BYTE_ZERO;
        end else if (i_cmd.wcnt) begin
            mem_wdata = r_cwr[31:24];
        end else begin
            mem_wdata = r_wsh[63:56];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end else begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_size  <= i_size_code;
            r_dbase <= i_data_base;
            r_cbase <= i_counter_base;
            r_err   <= cnt_err;
            r_best  <= (i_op == wlss_pkg::OP_READ) ? 32'd0 : wlss_pkg::CNT_MAX;
            r_slot  <= '0;
            r_acc   <= 64'd0;
        end else begin
            if (scan_hit && better) begin
                r_best <= cval;
                r_slot <= r_rbi[K_W-1:2];
            end
            if (r_rv && !r_rscan) begin
                r_acc <= {r_acc[55:0], r_rd_data};
            end
            if (i_cmd.check) begin
                r_err <= data_err;
            end
        end

        if (i_cmd.load) begin
            r_wsh <= wsh_load;
        end else if (i_cmd.wval) begin
            r_wsh <= {r_wsh[55:0], wlss_pkg::BYTE_ZERO};
        end

        if (i_cmd.check) begin
            r_caddr <= caddr;
            r_vaddr <= vaddr;
            r_cwr   <= r_best + 32'd1;
        end else if (i_cmd.wcnt) begin
            r_cwr <= {r_cwr[23:0], wlss_pkg::BYTE_ZERO};
        end

        if (r_rv && r_rscan) begin
            r_cacc <= cval[23:0];
        end
        r_rbi <= r_k;

        if (i_cmd.finish) begin
            r_read_value <= r_acc;
            r_slot_used  <= slot_ext[2:0];
            r_status     <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_k        <= '0;
            r_rv       <= 1'b0;
            r_rscan    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            priority if (i_cmd.load || i_cmd.check) begin
                r_k <= '0;
            end else if (i_cmd.wcnt && o_sts.cnt_last) begin
                r_k <= '0;
            end else if (i_cmd.scan || i_cmd.wcnt || i_cmd.wval || i_cmd.rval) begin
                r_k <= r_k + K_W'(1);
            end else begin
                r_k <= r_k;
            end
            r_rv    <= i_cmd.scan || i_cmd.rval;
            r_rscan <= i_cmd.scan;
            r_done  <= i_cmd.finish;
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr_addr == CLR_LAST);
        o_sts.cnt_err   = cnt_err;
        o_sts.scan_last = (r_k == SCAN_LAST);
        o_sts.data_err  = data_err;
        o_sts.cnt_last  = (r_k == CNT_LAST);
        o_sts.val_last  = (r_k == K_W'(val_last_idx));
        o_sts.op        = r_op;
    end

    assign o_read_value = r_read_value;
    assign o_slot_used  = r_slot_used;
    assign o_status     = r_status;
    assign o_done       = r_done;

endmodule

// ----- rtl/wear_leveled_slot_store_core.sv -----
// Top level of the wear-leveled slot store: controller plus datapath.
// Depends on wlss_pkg, wlss_ctrl and wlss_datapath.
//
// Usage:
//   Request channel: drive i_op, i_size_code, i_data_base, i_counter_base and
//   i_write_value and raise start; a request is taken at a clock edge where
//   start is high and busy is low. Fields are captured at that edge.
//   Result channel: o_read_value, o_slot_used and o_status are valid for the
//   single cycle where o_done is high. There is no backpressure; capture them
//   in that cycle.
// Sequence (one byte port to the memory serves every step):
//   Write: counter scan, slot check, counter bytes, then value bytes.
//   Read: counter scan, slot check, value bytes. Counter range error: no scan.
//   Slot range error: ends after the slot check. The next request can be taken in the o_done
//   cycle. The counter scan reads 4 * SLOT_COUNT bytes, one per cycle.
// Reset: synchronous, active low. After reset the block sweeps the memory to
//   zero, one byte per cycle (all MEM_BYTES bytes, 4096 by default), holding busy
//   high; no request is taken until the sweep ends.
module wear_leveled_slot_store_core #(
    parameter int MEM_BYTES  = wlss_pkg::MEM_BYTES_DEF,
    parameter int SLOT_COUNT = wlss_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [1:0]  i_size_code,
    input  logic [11:0] i_data_base,
    input  logic [11:0] i_counter_base,
    input  logic [63:0] i_write_value,
    output logic        o_done,
    output logic [63:0] o_read_value,
    output logic [2:0]  o_slot_used,
    output logic        o_status
);

    // Command and status between sequencer and datapath
    wlss_pkg::t_cmd cmd;
    wlss_pkg::t_sts sts;

    // Sequencer: clear sweep, scan, then write or read phase
    wlss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath: byte memory, counter compare, address and range checks
    wlss_datapath #(
        .MEM_BYTES  (MEM_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_size_code    (i_size_code),
        .i_data_base    (i_data_base),
        .i_counter_base (i_counter_base),
        .i_write_value  (i_write_value),
        .o_sts          (sts),
        .o_read_value   (o_read_value),
        .o_slot_used    (o_slot_used),
        .o_status       (o_status),
        .o_done         (o_done)
    );

endmodule

// ----- rtl/wlss_checker.sv -----
// Port-level checker for the slot store, bound to the top level.
// Depends on wear_leveled_slot_store_core_macros.svh.
`include "wear_leveled_slot_store_core_macros.svh"

module wlss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_status,
    input logic [63:0] o_read_value
);

    `WLSS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `WLSS_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `WLSS_ASSERT_IMPLY(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))
    `WLSS_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_done && o_status, o_read_value == 64'd0)
    `WLSS_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)

endmodule

bind wear_leveled_slot_store_core wlss_checker u_wlss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_read_value (o_read_value)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for wear_leveled_slot_store_core: directed table, then random requests.
// Depends on wlss_pkg and the RTL of wear_leveled_slot_store_core; reads no files.
module tb;
    import wlss_pkg::*;

    localparam int MEM_N          = MEM_BYTES_DEF;
    localparam int SLOT_N         = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS   = 400;
    localparam int DIRECTED_ROWS  = 25;
    localparam int MAX_REPORTS    = 10;
    // Longest quiet stretch: the post-reset clearing sweep plus slack, several times over.
    localparam int WATCHDOG_LIMIT = 4 * MEM_N + 4000;
    // Settling time after the last result, above the slowest request.
    localparam int DRAIN_CYCLES   = 64;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;
    localparam logic CHK_MODEL = 1'b0;
    localparam logic CHK_TYPED = 1'b1;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  slot;
        logic        status;
    } t_slot_result;

    typedef struct packed {
        logic         op;
        logic [1:0]   size_code;
        logic [11:0]  dbase;
        logic [11:0]  cbase;
        logic [63:0]  wval;
        logic         check;
        t_slot_result want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_op;
    logic [1:0]  i_size_code;
    logic [11:0] i_data_base;
    logic [11:0] i_counter_base;
    logic [63:0] i_write_value;
    logic        o_done;
    logic [63:0] o_read_value;
    logic [2:0]  o_slot_used;
    logic        o_status;

    // Byte image of the store as the block should hold it.
    logic [7:0]   mem_image [MEM_N];
    t_slot_result pending_results [$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           burst_left;
    t_dir_row     directed_rows [DIRECTED_ROWS];

    wear_leveled_slot_store_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_size_code    (i_size_code),
        .i_data_base    (i_data_base),
        .i_counter_base (i_counter_base),
        .i_write_value  (i_write_value),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_slot_used    (o_slot_used),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Big-endian fetch of len bytes, wrapping at the end of the image.
    function automatic logic [63:0] fetch_be(input int unsigned addr, input int unsigned len);
        logic [63:0] acc;
        acc = '0;
        for (int unsigned k = 0; k < len; k++) begin
            acc = {acc[55:0], mem_image[(addr + k) % MEM_N]};
        end
        return acc;
    endfunction

    // Big-endian store of the low len bytes of v.
    function automatic void store_be(input int unsigned addr, input int unsigned len,
                                     input logic [63:0] v);
        for (int unsigned k = 0; k < len; k++) begin
            mem_image[(addr + k) % MEM_N] = v[8 * (len - 1 - k) +: 8];
        end
    endfunction

    // Apply one request to the image and return the result the block owes for it.
    function automatic t_slot_result predict_access(input logic op, input logic [1:0] size_code,
                                                    input logic [11:0] dbase,
                                                    input logic [11:0] cbase,
                                                    input logic [63:0] wval);
        t_slot_result r;
        int unsigned  sz;
        int unsigned  slot;
        int unsigned  db;
        int unsigned  cb;
        logic [63:0]  word;
        logic [31:0]  cnt;
        logic [31:0]  pick;
        r    = '0;
        sz   = 1 << size_code;
        slot = 0;
        db   = 32'(dbase);
        cb   = 32'(cbase);
        if (cb + CNT_BYTES * SLOT_N > MEM_N) begin
            // Counter block runs off the end: nothing scanned, slot reported as zero.
            r.status = ST_RANGE;
        end else if (op == OP_WRITE) begin
            // First strictly lowest counter wins; all at maximum falls back to slot zero.
            pick = CNT_MAX;
            for (int unsigned i = 0; i < SLOT_N; i++) begin
                word = fetch_be(cb + CNT_BYTES * i, CNT_BYTES);
                cnt  = word[31:0];
                if (cnt < pick) begin
                    pick = cnt;
                    slot = i;
                end
            end
            if (db + (slot + 1) * sz > MEM_N) begin
                r.status = ST_RANGE;
            end else begin
                // Counter first, value second: value bytes win where regions overlap.
                store_be(cb + CNT_BYTES * slot, CNT_BYTES, {32'd0, pick + 32'd1});
                store_be(db + slot * sz, sz, wval);
            end
        end else begin
            // Last counter at the highest value wins.
            pick = '0;
            for (int unsigned i = 0; i < SLOT_N; i++) begin
                word = fetch_be(cb + CNT_BYTES * i, CNT_BYTES);
                cnt  = word[31:0];
                if (cnt >= pick) begin
                    pick = cnt;
                    slot = i;
                end
            end
            if (db + (slot + 1) * sz > MEM_N) begin
                r.status = ST_RANGE;
            end else begin
                r.value = fetch_be(db + slot * sz, sz);
            end
        end
        r.slot = slot[2:0];
        return r;
    endfunction

    // Present one request, hold it until taken, then log what the block owes.
    // The sender runs in bursts; at the end of a burst drop start for a random gap.
    task automatic send_request(input logic op, input logic [1:0] size_code,
                                input logic [11:0] dbase, input logic [11:0] cbase,
                                input logic [63:0] wval, input logic check,
                                input t_slot_result want);
        t_slot_result predicted;
        int           gap;
        start          <= 1'b1;
        i_op           <= op;
        i_size_code    <= size_code;
        i_data_base    <= dbase;
        i_counter_base <= cbase;
        i_write_value  <= wval;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // Advance the image even when the expectation is typed in.
        predicted = predict_access(op, size_code, dbase, cbase, wval);
        pending_results.push_back(check == CHK_TYPED ? want : predicted);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input t_slot_result want, input t_slot_result got,
                                 input logic orphan);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (orphan) begin
                $display("[%0t] unexpected result: value=%h slot=%0d status=%0d",
                         $realtime, got.value, got.slot, got.status);
            end else begin
                $display("[%0t] mismatch: value exp=%h got=%h",
                         $realtime, want.value, got.value);
                $display("    slot exp=%0d got=%0d status exp=%0d got=%0d",
                         want.slot, got.slot, want.status, got.status);
            end
        end
    endtask

    // Result checker: the block cannot be held off, so take every strobe as it comes.
    always @(posedge i_clk) begin
        t_slot_result got;
        t_slot_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            got = {o_read_value, o_slot_used, o_status};
            if (pending_results.size() == 0) begin
                note_mismatch('0, got, 1'b1);
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.slot !== want.slot
                    || got.status !== want.status) begin
                    note_mismatch(want, got, 1'b0);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("wear_leveled_slot_store_core regression: fail");
            $finish;
        end
    end

    initial begin
        logic        op;
        logic [1:0]  size_code;
        logic [11:0] dbase;
        logic [11:0] cbase;
        int          seq_len;
        int          mode;
        int          sent;
        int unsigned sz;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_op           = OP_WRITE;
        i_size_code    = SIZE_1B;
        i_data_base    = '0;
        i_counter_base = '0;
        i_write_value  = '0;
        burst_left     = $urandom_range(1, 30);
        for (int i = 0; i < MEM_N; i++) mem_image[i] = 8'h00;

        // Directed rows: error paths, extremes, then the all-counters-at-max walk.
        directed_rows = '{
            // Fresh store: all counters zero, read picks the last slot and sees zero.
            '{OP_READ,  SIZE_1B, 12'd0,    12'd0,    64'h0, CHK_TYPED, '{64'h0, 3'd7, ST_OK}},
            // Chosen slot runs past the end.
            '{OP_READ,  SIZE_8B, 12'd4095, 12'd0,    64'h0, CHK_TYPED, '{64'h0, 3'd7, ST_RANGE}},
            '{OP_WRITE, SIZE_8B, 12'd4090, 12'd0,    64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd0, ST_RANGE}},
            // Counter block runs past the end.
            '{OP_WRITE, SIZE_1B, 12'd0,    12'd4065, 64'h1, CHK_TYPED, '{64'h0, 3'd0, ST_RANGE}},
            '{OP_READ,  SIZE_2B, 12'd0,    12'd4095, 64'h0, CHK_TYPED, '{64'h0, 3'd0, ST_RANGE}},
            '{OP_WRITE, SIZE_1B, 12'd100,  12'd200,  64'h0123_4567_89AB_CDA5,
              CHK_TYPED, '{64'h0, 3'd0, ST_OK}},
            '{OP_READ,  SIZE_1B, 12'd100,  12'd200,  64'h0, CHK_TYPED, '{64'hA5, 3'd0, ST_OK}},
            // Counter block flush against the end of memory.
            '{OP_WRITE, SIZE_2B, 12'd300,  12'd4064, 64'hFFFF_FFFF_FFFF_1234,
              CHK_TYPED, '{64'h0, 3'd0, ST_OK}},
            '{OP_READ,  SIZE_2B, 12'd300,  12'd4064, 64'h0, CHK_TYPED, '{64'h1234, 3'd0, ST_OK}},
            // Value flush against the end of memory.
            '{OP_WRITE, SIZE_8B, 12'd4088, 12'd0,    64'h0123_4567_89AB_CDEF,
              CHK_TYPED, '{64'h0, 3'd0, ST_OK}},
            '{OP_READ,  SIZE_8B, 12'd4088, 12'd0,    64'h0,
              CHK_TYPED, '{64'h0123_4567_89AB_CDEF, 3'd0, ST_OK}},
            // Value array laid over the counters: each write pins its counter at maximum.
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd0, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd1, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd2, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd3, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd4, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd5, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd6, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd512, 12'd512, 64'hFFFF_FFFF_FFFF_FFFF,
              CHK_TYPED, '{64'h0, 3'd7, ST_OK}},
            '{OP_READ,  SIZE_4B, 12'd512, 12'd512, 64'h0,
              CHK_TYPED, '{64'hFFFF_FFFF, 3'd7, ST_OK}},
            // All counters at maximum: write falls back to slot zero and wraps its counter.
            '{OP_WRITE, SIZE_4B, 12'd600, 12'd512, 64'h5A5A_5A5A,
              CHK_TYPED, '{64'h0, 3'd0, ST_OK}},
            '{OP_READ,  SIZE_4B, 12'd600, 12'd512, 64'h0, CHK_TYPED, '{64'h0, 3'd7, ST_OK}},
            '{OP_WRITE, SIZE_4B, 12'd600, 12'd512, 64'hDEAD_BEEF,
              CHK_TYPED, '{64'h0, 3'd0, ST_OK}},
            '{OP_READ,  SIZE_4B, 12'd600, 12'd512, 64'h0, CHK_MODEL, '0},
            '{OP_WRITE, SIZE_8B, 12'd700, 12'd800, 64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, '0}
        };

        // Hold reset, then release it at a rising edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The clearing sweep keeps busy high; send_request simply waits it out.
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].size_code,
                         directed_rows[i].dbase, directed_rows[i].cbase,
                         directed_rows[i].wval, directed_rows[i].check,
                         directed_rows[i].want);
        end
        drain_results();

        // Random part: mostly runs of requests against one counter and value layout,
        // so counters climb and reads land on written data; the rest is pure noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode <= 6) begin
                size_code = 2'($urandom_range(0, 3));
                sz        = 1 << size_code;
                cbase     = 12'($urandom_range(0, MEM_N - CNT_BYTES * SLOT_N));
                case ($urandom_range(0, 7))
                    0: begin
                        // Overlay values on counters.
                        dbase = cbase;
                    end
                    1: begin
                        // Straddle the end: some slots fit, later ones do not.
                        dbase = 12'($urandom_range(MEM_N - SLOT_N * sz, MEM_N - 1));
                    end
                    default: begin
                        dbase = 12'($urandom_range(0, MEM_N - SLOT_N * sz));
                    end
                endcase
                seq_len = $urandom_range(4, 16);
                for (int k = 0; k < seq_len && sent < RANDOM_ITEMS; k++) begin
                    op = ($urandom_range(0, 2) == 0) ? OP_READ : OP_WRITE;
                    send_request(op, size_code, dbase, cbase, {$urandom, $urandom},
                                 CHK_MODEL, '0);
                    sent++;
                end
            end else if (mode <= 8) begin
                send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             12'($urandom_range(0, MEM_N - 1)),
                             12'($urandom_range(0, MEM_N - 1)),
                             {$urandom, $urandom}, CHK_MODEL, '0);
                sent++;
            end else begin
                drain_results();
            end
        end

        // Wait for every owed result, then let the block settle before judging.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("wear_leveled_slot_store_core regression: pass");
        end else begin
            $display("wear_leveled_slot_store_core regression: fail");
        end
        $finish;
    end

endmodule
